// ----- rtl/core/isc_pkg.sv -----
// isc_pkg: shared types and codes for the interval stabbing counter.
// Used by isc_cell and interval_stabbing_counter_core. No dependencies.
package isc_pkg;

    localparam int unsigned MAX_INTERVALS_DEF = 64;
    localparam int unsigned TIME_WIDTH_DEF    = 32;
    localparam int unsigned FIELD_TIME_W      = 32;
    localparam int unsigned COUNT_FIELD_W     = 7;

    // kind field codes
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // operation carried down the cell chain
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       status;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0]              kind;
        logic [FIELD_TIME_W-1:0] interval_start;
        logic [FIELD_TIME_W-1:0] interval_end;
        logic [FIELD_TIME_W-1:0] query_point;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_FIELD_W-1:0] active_count;
        logic                     status;
    } t_out_word;

endpackage

// ----- rtl/core/isc_cell.sv -----
// isc_cell: one table slot of the stabbing counter chain. Holds one interval,
// stores it on a matching load, adds its hit to a passing query. Uses isc_pkg.
module isc_cell
    import isc_pkg::*;
#(
    parameter int unsigned IDX        = 0,
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int unsigned CW         = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_cell_ctl             i_ctl,
    input  logic [CW-1:0]         i_lim,
    input  logic [TIME_WIDTH-1:0] i_a,
    input  logic [TIME_WIDTH-1:0] i_b,
    input  logic [CW-1:0]         i_cnt,
    output t_cell_ctl             o_ctl,
    output logic [CW-1:0]         o_lim,
    output logic [TIME_WIDTH-1:0] o_a,
    output logic [TIME_WIDTH-1:0] o_b,
    output logic [CW-1:0]         o_cnt
);

    logic [TIME_WIDTH-1:0] r_start, r_end;
    t_cell_ctl             r_ctl;
    logic [CW-1:0]         r_lim, r_cnt;
    logic [TIME_WIDTH-1:0] r_a, r_b;
    logic                  hit, wr;
    logic [CW-1:0]         n_cnt;

    // lim is entry count at issue: slot index for a load, bound for a query
    assign wr  = i_adv && i_ctl.valid && (i_ctl.op == OP_LOAD) && (i_lim == CW'(IDX));
    assign hit = i_ctl.valid && (i_ctl.op == OP_QUERY) && (i_lim > CW'(IDX)) &&
                 (r_start <= i_a) && (i_a <= r_end);
    assign n_cnt = i_cnt + CW'(hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lim <= i_lim;
            r_a   <= i_a;
            r_b   <= i_b;
            r_cnt <= n_cnt;
        end
        if (wr) begin
            r_start <= i_a;
            r_end   <= i_b;
        end
    end

    assign o_ctl = r_ctl;
    assign o_lim = r_lim;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_cnt = r_cnt;

endmodule

// ----- rtl/core/interval_stabbing_counter_core.sv -----
// interval_stabbing_counter_core: top level of the interval stabbing counter.
// Issue logic, entry count and a chain of isc_cell. Uses isc_pkg, isc_cell.

// Every input word (clear, load or query) gives one result word. Words flow
// in order through a row of MAX_INTERVALS cells, one cell per cycle, each
// cell holding one interval; a load is written by the cell whose index equals
// the entry count at issue, a query picks up one count from every filled cell
// whose interval holds its point. A word passes the registers of the whole cell
// chain from accept to result; one word is accepted per cycle while the result
// side keeps up, and the whole chain holds while a result waits under stall.
// A load into a full table is dropped with status 1; clear takes effect for
// the next word.
module interval_stabbing_counter_core
    import isc_pkg::*;
#(
    parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int unsigned TIME_WIDTH    = TIME_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
    localparam int unsigned N  = MAX_INTERVALS;

    logic          adv, acc, full;
    logic [CW-1:0] r_count, n_count;

    t_cell_ctl             ctl [0:N];
    logic [CW-1:0]         lim [0:N];
    logic [TIME_WIDTH-1:0] ta  [0:N];
    logic [TIME_WIDTH-1:0] tb  [0:N];
    logic [CW-1:0]         cnt [0:N];

    logic [TIME_WIDTH-1:0] s_t, e_t, p_t;

    // chain moves unless a finished result is held back
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;
    assign acc     = i_valid && adv;
    assign full    = (r_count == CW'(MAX_INTERVALS));

    // timestamps masked or widened to TIME_WIDTH
    generate
        if (TIME_WIDTH > FIELD_TIME_W) begin : g_wide
            assign s_t = {{(TIME_WIDTH-FIELD_TIME_W){1'b0}}, i_word.interval_start};
            assign e_t = {{(TIME_WIDTH-FIELD_TIME_W){1'b0}}, i_word.interval_end};
            assign p_t = {{(TIME_WIDTH-FIELD_TIME_W){1'b0}}, i_word.query_point};
        end else begin : g_narrow
            assign s_t = i_word.interval_start[TIME_WIDTH-1:0];
            assign e_t = i_word.interval_end[TIME_WIDTH-1:0];
            assign p_t = i_word.query_point[TIME_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        ctl[0]        = '0;
        ctl[0].valid  = acc;
        ctl[0].op     = OP_NONE;
        ctl[0].status = 1'b0;
        ta[0]         = p_t;
        tb[0]         = e_t;
        case (i_word.kind)
            KIND_LOAD: begin
                if (full) begin
                    ctl[0].status = 1'b1;
                end else begin
                    ctl[0].op = OP_LOAD;
                end
                ta[0] = s_t;
            end
            KIND_QUERY: begin
                ctl[0].op = OP_QUERY;
            end
            default: begin
                ctl[0].op = OP_NONE;
            end
        endcase
    end

    assign lim[0] = r_count;
    assign cnt[0] = '0;

    always_comb begin
        n_count = r_count;
        if (acc) begin
            case (i_word.kind)
                KIND_CLEAR: n_count = '0;
                KIND_LOAD:  if (!full) n_count = r_count + CW'(1);
                default:    n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    generate
        for (genvar k = 0; k < N; k++) begin : g_cell
            isc_cell #(
                .IDX        (k),
                .TIME_WIDTH (TIME_WIDTH),
                .CW         (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_ctl   (ctl[k]),
                .i_lim   (lim[k]),
                .i_a     (ta[k]),
                .i_b     (tb[k]),
                .i_cnt   (cnt[k]),
                .o_ctl   (ctl[k+1]),
                .o_lim   (lim[k+1]),
                .o_a     (ta[k+1]),
                .o_b     (tb[k+1]),
                .o_cnt   (cnt[k+1])
            );
        end
    endgenerate

    assign o_valid       = ctl[N].valid;
    assign o_word.status = ctl[N].status;

    // count field keeps the low bits when the table is deeper than 127
    generate
        if (CW >= COUNT_FIELD_W) begin : g_cnt_trunc
            assign o_word.active_count = cnt[N][COUNT_FIELD_W-1:0];
        end else begin : g_cnt_ext
            assign o_word.active_count = {{(COUNT_FIELD_W-CW){1'b0}}, cnt[N]};
        end
    endgenerate

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_INTERVALS))
        else $error("entry count above table depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_word.kind == KIND_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_drop_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.status) |-> (o_word.active_count == '0))
        else $error("dropped load carries a count");

    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_word.kind == KIND_LOAD && full) |=> (r_count == $past(r_count)))
        else $error("dropped load changed the entry count");

endmodule
